// File: rtl/core/facd_pkg.sv
package facd_pkg;

  // Text store size and derived widths
  localparam int unsigned MAX_TEXT = 31;
  localparam int unsigned IDX_W    = $clog2(MAX_TEXT);
  localparam int unsigned LEN_W    = $clog2(MAX_TEXT + 1);

  // Leading characters of the trimmed text that the decoder looks at
  localparam int unsigned CH_N = 5;

  // Payload widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CODE_W = 5;
  localparam int unsigned ARG_W  = 10;
  localparam int unsigned STAT_W = 3;

  // Framing and character constants
  localparam logic [7:0] OPEN_MARK  = 8'h3C;
  localparam logic [7:0] CLOSE_MARK = 8'h3E;
  localparam logic [7:0] PRINT_LOW  = 8'd32;
  localparam logic [7:0] PRINT_HIGH = 8'd126;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_A       = 8'h41;

  // Command codes with an argument, and the top valid code
  localparam logic [CODE_W-1:0] CODE_ARG3 = 5'd10;
  localparam logic [CODE_W-1:0] CODE_ARG2 = 5'd16;
  localparam logic [7:0]        CODE_MAX  = 8'h13;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_UNKNOWN   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_LEN   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NON_DIGIT = 3'd3;
  localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd4;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [3:0] dec_val(input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    return d[3:0];
  endfunction

  // {valid, value} of an upper-case hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'b0_0000;
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if ((c >= 8'h61) && (c <= 8'h7A)) begin
      return c - 8'h20;
    end
    return c;
  endfunction

endpackage

// File: rtl/core/facd_if.sv
// Input channel: one received byte per beat
interface facd_in_if;
  logic                        valid;
  logic                        ready;
  logic [facd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel: one decoded command per beat
interface facd_out_if;
  logic                        valid;
  logic                        ready;
  logic [facd_pkg::CODE_W-1:0] command_code;
  logic [facd_pkg::ARG_W-1:0]  argument;
  logic [facd_pkg::STAT_W-1:0] status;

  modport source (output valid, output command_code, output argument, output status,
                  input ready);
  modport sink   (input valid, input command_code, input argument, input status,
                  output ready);
endinterface

// File: rtl/core/facd_ram.sv
module facd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/framed_ascii_command_decoder.sv
// Framed ASCII command decoder. Bytes arrive one per beat; '<' opens a frame and
// empties the text, printable bytes are stored (up to 31, later ones dropped) and
// '>' closes the frame. After a closing '>' of a frame holding bytes, the text
// memory is read back one byte per cycle through its single read port to find the
// trimmed text, then the decode state decodes it, waiting there while an earlier
// result still waits in the output register. A frame holding a non-space byte
// gives one result beat: command code, argument and status. The input is not
// ready during that walk; the result sits in an output register, so bytes keep
// flowing while it waits to be taken.
module framed_ascii_command_decoder (
  input  logic       clk,
  input  logic       rst_n,
  facd_in_if.sink    in_ch,
  facd_out_if.source out_ch
);
  import facd_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DECODE} state_t;

  state_t             state_r, state_nxt;
  logic               in_frame_r, in_frame_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [LEN_W-1:0]   issue_r, issue_nxt;
  logic [IDX_W-1:0]   data_idx_r, data_idx_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   s_r, s_nxt;
  logic [IDX_W-1:0]   last_r, last_nxt;
  logic [7:0]         ch_r [0:CH_N-1];
  logic [7:0]         ch_nxt [0:CH_N-1];
  logic               out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]  out_code_r, out_code_nxt;
  logic [ARG_W-1:0]   out_arg_r, out_arg_nxt;
  logic [STAT_W-1:0]  out_stat_r, out_stat_nxt;

  logic               in_fire;
  logic [7:0]         rx;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_raddr;
  logic [7:0]         ram_rdata;

  logic [7:0]         scan_b;
  logic               scan_sp;
  logic [IDX_W-1:0]   scan_s;
  logic [IDX_W-1:0]   scan_k;

  logic [LEN_W-1:0]   trim_len;
  logic               pre_0a, pre_10;
  logic               dig2, dig3, dig4;
  logic [ARG_W-1:0]   val3, val2;
  logic [4:0]         hx_h, hx_l;
  logic [7:0]         hx_code;
  logic [CODE_W-1:0]  dec_code;
  logic [ARG_W-1:0]   dec_arg;
  logic [STAT_W-1:0]  dec_stat;

  // Handshake
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign rx          = in_ch.rx_byte;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.command_code = out_code_r;
  assign out_ch.argument     = out_arg_r;
  assign out_ch.status       = out_stat_r;

  // Text store
  assign ram_we = in_fire && in_frame_r && (rx != OPEN_MARK) && (rx != CLOSE_MARK) &&
                  (rx >= PRINT_LOW) && (rx <= PRINT_HIGH) &&
                  (len_r < LEN_W'(MAX_TEXT));
  assign ram_raddr = (state_r == ST_SCAN) ? issue_r[IDX_W-1:0] : '0;

  facd_ram #(
    .WIDTH (8),
    .DEPTH (MAX_TEXT)
  ) u_text_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r[IDX_W-1:0]),
    .wdata (rx),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Scan of one stored byte: position relative to the first non-space
  assign scan_b  = upcase(ram_rdata);
  assign scan_sp = (ram_rdata == CH_SPACE);
  assign scan_s  = found_r ? s_r : data_idx_r;
  assign scan_k  = data_idx_r - scan_s;

  // Decode of the trimmed text
  assign trim_len = LEN_W'(last_r - s_r) + LEN_W'(1);
  assign pre_0a   = (trim_len >= LEN_W'(2)) && (ch_r[0] == CH_ZERO) && (ch_r[1] == CH_A);
  assign pre_10   = (trim_len >= LEN_W'(2)) && (ch_r[0] == CH_ONE) && (ch_r[1] == CH_ZERO);
  assign dig2     = is_dec(ch_r[2]);
  assign dig3     = is_dec(ch_r[3]);
  assign dig4     = is_dec(ch_r[4]);
  assign val3     = ARG_W'(dec_val(ch_r[2])) * ARG_W'(100) +
                    ARG_W'(dec_val(ch_r[3])) * ARG_W'(10) + ARG_W'(dec_val(ch_r[4]));
  assign val2     = ARG_W'(dec_val(ch_r[2])) * ARG_W'(10) + ARG_W'(dec_val(ch_r[3]));
  assign hx_h     = hex_val(ch_r[0]);
  assign hx_l     = hex_val(ch_r[1]);
  assign hx_code  = {hx_h[3:0], hx_l[3:0]};

  always_comb begin
    dec_code = '0;
    dec_arg  = '0;
    dec_stat = STAT_UNKNOWN;
    if (pre_0a) begin
      dec_code = CODE_ARG3;
      if (trim_len != LEN_W'(5)) begin
        dec_stat = STAT_BAD_LEN;
      end else if (!(dig2 && dig3 && dig4)) begin
        dec_stat = STAT_NON_DIGIT;
      end else if (val3 == '0) begin
        dec_stat = STAT_RANGE;
      end else begin
        dec_stat = STAT_OK;
        dec_arg  = val3;
      end
    end else if (pre_10) begin
      dec_code = CODE_ARG2;
      if (trim_len != LEN_W'(4)) begin
        dec_stat = STAT_BAD_LEN;
      end else if (!(dig2 && dig3)) begin
        dec_stat = STAT_NON_DIGIT;
      end else begin
        dec_stat = STAT_OK;
        dec_arg  = val2;
      end
    end else if (trim_len == LEN_W'(2)) begin
      if (hx_h[4] && hx_l[4] && (hx_code <= CODE_MAX)) begin
        dec_code = hx_code[CODE_W-1:0];
        dec_stat = STAT_OK;
      end
    end
  end

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    in_frame_nxt  = in_frame_r;
    len_nxt       = len_r;
    issue_nxt     = issue_r;
    data_idx_nxt  = data_idx_r;
    found_nxt     = found_r;
    s_nxt         = s_r;
    last_nxt      = last_r;
    ch_nxt        = ch_r;
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    out_arg_nxt   = out_arg_r;
    out_stat_nxt  = out_stat_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (rx == OPEN_MARK) begin
            in_frame_nxt = 1'b1;
            len_nxt      = '0;
          end else if ((rx == CLOSE_MARK) && in_frame_r) begin
            in_frame_nxt = 1'b0;
            found_nxt    = 1'b0;
            data_idx_nxt = '0;
            issue_nxt    = LEN_W'(1);
            if (len_r != '0) begin
              state_nxt = ST_SCAN;
            end
          end else if (ram_we) begin
            len_nxt = len_r + LEN_W'(1);
          end
        end
      end
      ST_SCAN: begin
        // ram_rdata holds the byte at data_idx_r
        if (!scan_sp) begin
          found_nxt = 1'b1;
          last_nxt  = data_idx_r;
          if (!found_r) begin
            s_nxt = data_idx_r;
          end
        end
        if ((found_r || !scan_sp) && (scan_k < IDX_W'(CH_N))) begin
          ch_nxt[scan_k[$clog2(CH_N)-1:0]] = scan_b;
        end
        if (issue_r < len_r) begin
          issue_nxt = issue_r + LEN_W'(1);
        end
        data_idx_nxt = data_idx_r + IDX_W'(1);
        if (LEN_W'(data_idx_r) == len_r - LEN_W'(1)) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!found_r) begin
          len_nxt   = '0;
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = dec_code;
          out_arg_nxt   = dec_arg;
          out_stat_nxt  = dec_stat;
          len_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_frame_r  <= 1'b0;
      len_r       <= '0;
      issue_r     <= '0;
      data_idx_r  <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_frame_r  <= in_frame_nxt;
      len_r       <= len_nxt;
      issue_r     <= issue_nxt;
      data_idx_r  <= data_idx_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      s_r         <= s_nxt;
      last_r      <= last_nxt;
      ch_r        <= ch_nxt;
      out_code_r  <= out_code_nxt;
      out_arg_r   <= out_arg_nxt;
      out_stat_r  <= out_stat_nxt;
    end
  end

  // Checks
  a_result_from_decode: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DECODE))
    else $error("result beat raised outside decode");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(MAX_TEXT))
    else $error("text length past store size");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (LEN_W'(data_idx_r) < len_r))
    else $error("scan index past text length");

  a_arg3_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_stat_r == STAT_OK) && (out_code_r == CODE_ARG3)) |->
      (out_arg_r != '0))
    else $error("three-digit argument accepted as zero");

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

import facd_pkg::*;

// One decoded command as it leaves the block
typedef struct packed {
  logic [CODE_W-1:0] code;
  logic [ARG_W-1:0]  arg;
  logic [STAT_W-1:0] status;
} command_beat_t;

// Tracks the frame state, decodes each closed frame and holds the commands in flight
class command_scoreboard;
  bit                frame_open;
  logic [BYTE_W-1:0] text[MAX_TEXT];
  int unsigned       text_len;
  logic [BYTE_W-1:0] trimmed[MAX_TEXT];
  int unsigned       trimmed_len;
  command_beat_t     pending[$];
  int unsigned       errors;
  int unsigned       results_seen;

  task report(string what);
    errors++;
    $display("[%0t] %s", $time, what);
  endtask

  // Upper-case hex digit weight, -1 when not a hex digit
  function int hex_weight(logic [BYTE_W-1:0] c);
    if (c >= CH_ZERO && c <= 8'h39) return int'(c - CH_ZERO);
    if (c >= CH_A && c <= 8'h46) return int'(c - CH_A) + 10;
    return -1;
  endfunction

  // Decimal value of trimmed[first +: count]; 0 when a non-digit shows up
  function bit read_decimal(int unsigned first, int unsigned count, output int unsigned value);
    value = 0;
    for (int unsigned i = first; i < first + count; i++) begin
      if (trimmed[i] < CH_ZERO || trimmed[i] > 8'h39) return 1'b0;
      value = value * 10 + int'(trimmed[i] - CH_ZERO);
    end
    return 1'b1;
  endfunction

  function command_beat_t decode_command();
    command_beat_t r;
    int unsigned   v;
    int            hi;
    int            lo;
    r.code   = '0;
    r.arg    = '0;
    r.status = STAT_UNKNOWN;
    if (trimmed_len >= 2 && trimmed[0] == CH_ZERO && trimmed[1] == CH_A) begin
      // three-digit argument, 001..999
      r.code = CODE_ARG3;
      if (trimmed_len != 5) r.status = STAT_BAD_LEN;
      else if (!read_decimal(2, 3, v)) r.status = STAT_NON_DIGIT;
      else if (v == 0 || v > 999) r.status = STAT_RANGE;
      else begin
        r.status = STAT_OK;
        r.arg    = v[ARG_W-1:0];
      end
    end else if (trimmed_len >= 2 && trimmed[0] == CH_ONE && trimmed[1] == CH_ZERO) begin
      // two-digit argument, 00..99
      r.code = CODE_ARG2;
      if (trimmed_len != 4) r.status = STAT_BAD_LEN;
      else if (!read_decimal(2, 2, v)) r.status = STAT_NON_DIGIT;
      else if (v > 99) r.status = STAT_RANGE;
      else begin
        r.status = STAT_OK;
        r.arg    = v[ARG_W-1:0];
      end
    end else if (trimmed_len == 2) begin
      hi = hex_weight(trimmed[0]);
      lo = hex_weight(trimmed[1]);
      if (hi >= 0 && lo >= 0 && hi * 16 + lo <= int'(CODE_MAX)) begin
        r.code   = CODE_W'(hi * 16 + lo);
        r.status = STAT_OK;
      end
    end
    return r;
  endfunction

  // One accepted input beat
  function void note_byte(logic [BYTE_W-1:0] b);
    int unsigned first;
    int unsigned last;
    if (b == OPEN_MARK) begin
      text_len   = 0;
      frame_open = 1'b1;
      return;
    end
    if (b == CLOSE_MARK && frame_open) begin
      frame_open = 1'b0;
      first = 0;
      while (first < text_len && text[first] == CH_SPACE) first++;
      last = text_len;
      while (last > first && text[last-1] == CH_SPACE) last--;
      text_len = 0;
      // blank frame: nothing comes out
      if (last == first) return;
      trimmed_len = last - first;
      for (int unsigned i = 0; i < trimmed_len; i++) begin
        trimmed[i] = text[first+i];
        if (trimmed[i] >= 8'h61 && trimmed[i] <= 8'h7A) trimmed[i] = trimmed[i] - 8'h20;
      end
      pending.push_back(decode_command());
      return;
    end
    // printable text is kept up to the store size, the rest dropped
    if (frame_open && b >= PRINT_LOW && b <= PRINT_HIGH && text_len < MAX_TEXT) begin
      text[text_len] = b;
      text_len++;
    end
  endfunction

  // One accepted result beat against the oldest expected command
  task check_result(command_beat_t got);
    command_beat_t want;
    results_seen++;
    if (pending.size() == 0) begin
      report($sformatf("unexpected result code=%0d arg=%0d status=%0d",
                       got.code, got.arg, got.status));
      return;
    end
    want = pending.pop_front();
    if (got.code !== want.code)
      report($sformatf("command_code got %0d want %0d", got.code, want.code));
    if (got.arg !== want.arg)
      report($sformatf("argument got %0d want %0d", got.arg, want.arg));
    if (got.status !== want.status)
      report($sformatf("status got %0d want %0d", got.status, want.status));
  endtask
endclass

module tb;
  logic clk;
  logic rst_n;

  facd_in_if  in_if();
  facd_out_if out_if();

  framed_ascii_command_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  command_scoreboard sb;
  bit                gaps_on;
  bit                hold_request;
  int unsigned       bytes_sent;
  logic [BYTE_W-1:0] burst[$];

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Overall time guard
  initial begin
    #3000000;
    $display("framed_ascii_command_decoder: mismatch");
    $finish;
  end

  // Offer one byte, optionally after a short idle burst, and wait for the beat
  task automatic send_byte(logic [BYTE_W-1:0] b);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    do begin
      @(posedge clk);
    end while (!in_if.ready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_burst();
    foreach (burst[i]) send_byte(burst[i]);
    burst.delete();
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) burst.push_back(s[i]);
  endtask

  // Letters go out in either case; now and then a control or high byte rides along
  task automatic push_char(logic [BYTE_W-1:0] c);
    if (c >= 8'h41 && c <= 8'h5A && $urandom_range(0, 1) == 1) c = c + 8'h20;
    burst.push_back(c);
    if ($urandom_range(0, 15) == 0)
      burst.push_back($urandom_range(0, 1) ? BYTE_W'($urandom_range(0, 31))
                                           : BYTE_W'($urandom_range(127, 255)));
  endtask

  task automatic push_spaces(int unsigned n);
    repeat (n) burst.push_back(CH_SPACE);
  endtask

  function automatic logic [BYTE_W-1:0] hex_char(int unsigned v);
    return (v < 10) ? BYTE_W'(8'h30 + v) : BYTE_W'(8'h37 + v);
  endfunction

  task automatic run_directed();
    // stray bytes with no frame open, byte extremes among them
    burst.push_back(CLOSE_MARK);
    burst.push_back(8'h00);
    burst.push_back(8'hFF);
    burst.push_back(CH_A);
    push_text("< 0a123 ><0A999><0A001><0A000><0A12><0A1x3>");
    push_text("<1000><1099><10 7><10x5><105><13><14><0f><F0><G1><1>");
    // empty and blank frames, reopen inside a frame, close twice
    push_text("<><   ><zz<12>>");
    // control and high bytes inside a frame are skipped
    burst.push_back(OPEN_MARK);
    burst.push_back(CH_ZERO);
    burst.push_back(8'h01);
    burst.push_back(CH_ONE);
    burst.push_back(8'h7F);
    burst.push_back(8'hFF);
    burst.push_back(8'h0A);
    burst.push_back(CLOSE_MARK);
    // text past the store size is dropped
    push_text("<");
    push_spaces(29);
    push_text("07XYZ>< 13");
    repeat (40) burst.push_back(8'h51);
    push_text(">");
    send_burst();
  endtask

  task automatic build_frame();
    int unsigned kind;
    int unsigned code;
    int unsigned n;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      // raw noise, marks included
      repeat ($urandom_range(1, 6)) burst.push_back(BYTE_W'($urandom_range(0, 255)));
      return;
    end
    burst.push_back(OPEN_MARK);
    push_spaces($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
    case (kind)
      0, 1, 2, 3: begin
        code = $urandom_range(0, 21);
        push_char(hex_char(code / 16));
        push_char(hex_char(code % 16));
      end
      4, 5: begin
        push_char(CH_ZERO);
        push_char(CH_A);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 3;
        if ($urandom_range(0, 7) == 0) push_text("000");
        else repeat (n) begin
          if ($urandom_range(0, 9) == 0) push_char(BYTE_W'($urandom_range(32, 126)));
          else push_char(BYTE_W'(8'h30 + $urandom_range(0, 9)));
        end
      end
      6: begin
        push_char(CH_ONE);
        push_char(CH_ZERO);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 2;
        repeat (n) begin
          if ($urandom_range(0, 9) == 0) push_char(BYTE_W'($urandom_range(32, 126)));
          else push_char(BYTE_W'(8'h30 + $urandom_range(0, 9)));
        end
      end
      7: begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4);
        repeat (n) push_char(BYTE_W'($urandom_range(32, 126)));
      end
      default: begin
        push_char(BYTE_W'($urandom_range(32, 126)));
        push_char(BYTE_W'($urandom_range(32, 126)));
      end
    endcase
    push_spaces($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
    // a frame left open now and then is cut short by the next open mark
    if ($urandom_range(0, 19) != 0) burst.push_back(CLOSE_MARK);
  endtask

  task automatic run_random();
    int unsigned frame_no;
    int unsigned start;
    frame_no = 0;
    start    = bytes_sent;
    while (bytes_sent - start < 250) begin
      if (bytes_sent - start >= 200) gaps_on = 1'b0;
      // long result-side hold while frames keep coming
      if (frame_no == 8 || frame_no == 32) hold_request = 1'b1;
      // drain everything before going on
      if (frame_no == 20) begin
        in_if.valid <= 1'b0;
        do begin
          @(posedge clk);
        end while (sb.pending.size() != 0);
      end
      build_frame();
      send_burst();
      frame_no++;
    end
  endtask

  // Result side: check each accepted beat, then choose ready for the next cycle
  initial begin
    int unsigned   stall_left;
    command_beat_t got;
    stall_left   = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got = {out_if.command_code, out_if.argument, out_if.status};
        sb.check_result(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = 150;
      end else if (stall_left == 0 && gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    sb            = new();
    gaps_on       = 1'b1;
    hold_request  = 1'b0;
    bytes_sent    = 0;
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.rx_byte <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    in_if.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (sb.pending.size() != 0);
    // room for a stray extra beat to show up
    repeat (60) @(posedge clk);
    if (sb.errors == 0) begin
      $display("framed_ascii_command_decoder: match");
    end else begin
      $display("framed_ascii_command_decoder: mismatch");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/core/facd_pkg.sv
rtl/core/facd_if.sv
rtl/core/facd_ram.sv
rtl/core/framed_ascii_command_decoder.sv
dv/tb.sv
